FILE: hdl/keyed_nearest_address_table_unit_assert.svh
// Assertion macros for the keyed nearest-address table unit.
`ifndef KEYED_NEAREST_ADDRESS_TABLE_UNIT_ASSERT_SVH
`define KEYED_NEAREST_ADDRESS_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define KNAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low
`define KNAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KNAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define KNAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/knat_pkg.sv
// Shared types and codes for the keyed nearest-address table unit.
package knat_pkg;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_BACK  = 2'd1,
        FUNC_FWD   = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int unsigned KEY_W = 31;
    localparam int unsigned LOC_W = 32;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   label_key;
        logic [LOC_W-1:0]   location;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [LOC_W-1:0]   found_location;
    } t_rsp;

    // One stored table entry
    typedef struct packed {
        logic [KEY_W-1:0]   label_key;
        logic [LOC_W-1:0]   location;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture request, do add or clear
        logic rd_en;    // read one entry for the scan
        logic finish;   // latch query result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic rd_last;
    } t_dp_stat;

endpackage

FILE: hdl/knat_ctrl.sv
// Sequencing state machine of the keyed nearest-address table unit.
module knat_ctrl
    import knat_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_func    i_func,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func inside {FUNC_BACK, FUNC_FWD}) begin
                        n_state = i_stat.count_zero ? S_FINISH : S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.rd_en  = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FINISH);
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= (n_state == S_RESP);
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

FILE: hdl/knat_datapath.sv
// Table memory, scan compare and result registers of the table unit.
module knat_datapath
    import knat_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_rsp     o_rsp
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_entry           mem [TABLE_DEPTH];

    t_func            r_func;
    logic [KEY_W-1:0] r_key;
    logic [LOC_W-1:0] r_ref;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_rd_idx;
    t_entry           r_rd_word;
    logic             r_cmp_vld;
    logic             r_have;
    logic [LOC_W-1:0] r_best;
    logic [1:0]       r_status;
    logic [LOC_W-1:0] r_found;

    logic             full;
    logic             side_ok;
    logic             better;
    logic             take;

    assign full = (r_count == CW'(TABLE_DEPTH));

    // Table memory: one write port for adds, one registered read port for scans
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_req.func == FUNC_ADD) && !full) begin
            mem[r_count[AW-1:0]] <= '{label_key: i_req.label_key,
                                      location:  i_req.location};
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= mem[r_rd_idx];
        end
    end

    // Compare the entry read last cycle against the best so far
    always_comb begin
        if (r_func == FUNC_FWD) begin
            side_ok = r_rd_word.location > r_ref;
            better  = !r_have || (r_rd_word.location < r_best);
        end else begin
            side_ok = r_rd_word.location <= r_ref;
            better  = !r_have || (r_rd_word.location > r_best);
        end
        take = r_cmp_vld && (r_rd_word.label_key == r_key) && side_ok && better;
    end

    // Control state: fill count and scan pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                if (i_req.func == FUNC_ADD && !full) begin
                    r_count <= r_count + CW'(1);
                end else if (i_req.func == FUNC_CLEAR) begin
                    r_count <= '0;
                end
            end
        end
    end

    // Request capture, scan progress and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_req.func;
            r_key    <= i_req.label_key;
            r_ref    <= i_req.location;
            r_rd_idx <= '0;
            r_have   <= 1'b0;
            r_found  <= '0;
            r_status <= (i_req.func == FUNC_ADD && full) ? ST_FULL : ST_OK;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
            if (take) begin
                r_have <= 1'b1;
                r_best <= r_rd_word.location;
            end
            if (i_cmd.finish) begin
                r_status <= r_have ? ST_OK : ST_MISS;
                r_found  <= r_have ? r_best : '0;
            end
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.rd_last    = ((CW'(r_rd_idx) + CW'(1)) == r_count);

    assign o_rsp.status         = r_status;
    assign o_rsp.found_location = r_found;

endmodule

FILE: hdl/keyed_nearest_address_table_unit.sv
// Keyed nearest-address table: add, backward/forward nearest query, clear.
// Add and clear: result strobe the cycle after the request is taken; busy for 1 cycle.
// Query: the scan reads each stored entry once through the single memory read port,
// then S_DRAIN, S_FINISH and S_RESP with the strobe; an empty table skips the scan.
// A new request is taken in the cycle after the strobe; the receiver cannot stall it.
// Synchronous active-low reset empties the table; the memory itself is not cleared.
`include "keyed_nearest_address_table_unit_assert.svh"
module keyed_nearest_address_table_unit
    import knat_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    knat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_req.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    knat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

    // A taken request holds the unit busy until its result is out
    `KNAT_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy,
                      "request not held busy")
    // After a result strobe the unit is free again
    `KNAT_ASSERT_NEXT(a_resp_idle, i_clk, i_rst_n, o_valid, !busy && !o_valid,
                      "unit stuck after result")
    // Misses and dropped adds report address zero
    `KNAT_ASSERT_NOW(a_zero_fail, i_clk, i_rst_n, o_valid && o_rsp.status != ST_OK,
                     o_rsp.found_location == '0, "non-zero address on failure")
    // Scan reads only happen inside a request
    `KNAT_ASSERT_NOW(a_scan_busy, i_clk, i_rst_n, cmd.rd_en, busy && !o_valid,
                     "scan read outside request")

endmodule
